// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, outside reset.
`define AST_IMPLY(lbl, clk, rstn, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |-> (con)) \
    else $error("assertion failed: implication");

// Condition must never hold, outside reset.
`define AST_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("assertion failed: forbidden condition");

`endif

// ===== sv/tia_pkg.sv =====
// ----------------------------------------------------------------------------
// tia_pkg
// Types, opcodes and width helpers of the tagged integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package tia_pkg;

  localparam int DataW    = 128;
  localparam int HalfW    = 64;
  localparam int DivSteps = 128;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_EQ   = 4'd4,
    OP_LT   = 4'd5,
    OP_LTE  = 4'd6,
    OP_NOT  = 4'd7,
    OP_SHL  = 4'd8,
    OP_SHR  = 4'd9,
    OP_CAST = 4'd10
  } opcode_t;

  typedef enum logic [2:0] {
    TAG_U8   = 3'd0,
    TAG_U16  = 3'd1,
    TAG_U32  = 3'd2,
    TAG_U64  = 3'd3,
    TAG_U128 = 3'd4
  } tag_t;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [2:0]  tag;
    logic [63:0] a_low;
    logic [63:0] a_high;
    logic [63:0] b_low;
    logic [63:0] b_high;
  } in_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic [63:0] remainder_low;
    logic [63:0] remainder_high;
    logic        carry;
    logic        shift_overflow;
    logic        divide_by_zero;
  } out_t;

  // Result of everything but the divider, carried alongside it.
  typedef struct packed {
    logic [DataW-1:0] res;
    logic             carry;
    logic             shovf;
    logic             dz;
    logic             is_div;
  } side_t;

  // Operand mask for a width tag; unknown tags act as 128 bits.
  function automatic logic [DataW-1:0] width_mask(logic [2:0] tag);
    logic [DataW-1:0] m;
    case (tag)
      TAG_U8:  m = {{(DataW-8){1'b0}}, {8{1'b1}}};
      TAG_U16: m = {{(DataW-16){1'b0}}, {16{1'b1}}};
      TAG_U32: m = {{(DataW-32){1'b0}}, {32{1'b1}}};
      TAG_U64: m = {{(DataW-64){1'b0}}, {64{1'b1}}};
      default: m = {DataW{1'b1}};
    endcase
    return m;
  endfunction

  // Width in bits for a tag, as a 9-bit value.
  function automatic logic [8:0] width_bits(logic [2:0] tag);
    logic [8:0] w;
    case (tag)
      TAG_U8:  w = 9'd8;
      TAG_U16: w = 9'd16;
      TAG_U32: w = 9'd32;
      TAG_U64: w = 9'd64;
      default: w = 9'd128;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tagged_integer_alu_top.sv =====
// ----------------------------------------------------------------------------
// tagged_integer_alu_top
// Width-tagged unsigned integer ALU, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and raise start; the beat is taken on any edge where start
//   is high and busy is low. busy is high only in reset and in the cycle after it, so
//   a new beat may be issued every cycle.
//   Each beat produces exactly one result beat: out_item is shown for one
//   cycle with out_valid high. The receiver must take it then.
// Pipeline, the same for every opcode: input register, an operand/ALU and
//   partial-product stage, a product sum stage, 128 divider stages (one
//   quotient bit each) and the output register.
// Throughput: one beat per cycle.
// Reset: rst_n is synchronous, active low; it drops every beat in flight.
// ----------------------------------------------------------------------------
`default_nettype none
module tagged_integer_alu_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire tia_pkg::in_t   in_item,
  output logic                out_valid,
  output tia_pkg::out_t       out_item
);
  import tia_pkg::*;

  logic busy_r;

  // Stage 1: input register
  logic v1_r;
  in_t  in_r;

  // Stage 2: masked operands, ALU results, partial products
  logic             v2_r;
  logic [3:0]       cmd2_r;
  logic [2:0]       tag2_r;
  logic [DataW-1:0] a2_r;
  logic [DataW-1:0] b2_r;
  logic [DataW-1:0] alu2_r;
  logic             carry2_r;
  logic             shovf2_r;
  logic [63:0]      pp_r [10];

  // Stage 3: selected side result into the divider
  logic             v3_r;
  logic [DataW-1:0] a3_r;
  logic [DataW-1:0] b3_r;
  side_t            side3_r;

  logic   out_valid_r;
  out_t   out_item_r;

  // Stage 2 logic
  logic [DataW-1:0] mask_s1;
  logic [DataW-1:0] a_s1;
  logic [DataW-1:0] b_s1;
  logic [DataW:0]   sum_s1;
  logic [DataW-1:0] dif_s1;
  logic [7:0]       cnt_s1;
  logic             ovf_s1;
  logic [DataW-1:0] alu_nxt;
  logic             carry_nxt;
  logic             shovf_nxt;
  logic [31:0]      ac [4];
  logic [31:0]      bc [4];

  // Stage 3 logic
  logic [DataW-1:0] prod_s2;
  side_t            side_nxt;

  // Divider outputs
  logic             dv_valid;
  logic [DataW-1:0] dv_quo;
  logic [DataW-1:0] dv_rem;
  side_t            dv_side;
  out_t             out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy_r;
    end
    in_r <= in_item;
  end

  always_comb begin
    mask_s1   = width_mask(in_r.tag);
    a_s1      = {in_r.a_high, in_r.a_low} & mask_s1;
    b_s1      = {in_r.b_high, in_r.b_low} & mask_s1;
    sum_s1    = {1'b0, a_s1} + {1'b0, b_s1};
    dif_s1    = a_s1 - b_s1;
    cnt_s1    = in_r.b_low[7:0];
    ovf_s1    = ({1'b0, cnt_s1} >= width_bits(in_r.tag));
    alu_nxt   = '0;
    carry_nxt = 1'b0;
    shovf_nxt = 1'b0;
    case (in_r.cmd)
      OP_ADD: begin
        alu_nxt   = sum_s1[DataW-1:0] & mask_s1;
        carry_nxt = |(sum_s1 & ~{1'b0, mask_s1});
      end
      OP_SUB: begin
        alu_nxt   = dif_s1 & mask_s1;
        carry_nxt = (a_s1 < b_s1);
      end
      OP_EQ:   alu_nxt = {{(DataW-1){1'b0}}, (a_s1 == b_s1)};
      OP_LT:   alu_nxt = {{(DataW-1){1'b0}}, (a_s1 < b_s1)};
      OP_LTE:  alu_nxt = {{(DataW-1){1'b0}}, !(b_s1 < a_s1)};
      OP_NOT:  alu_nxt = ~a_s1 & mask_s1;
      OP_SHL: begin
        shovf_nxt = ovf_s1;
        alu_nxt   = ovf_s1 ? '0 : ((a_s1 << cnt_s1) & mask_s1);
      end
      OP_SHR: begin
        shovf_nxt = ovf_s1;
        alu_nxt   = ovf_s1 ? '0 : (a_s1 >> cnt_s1);
      end
      OP_CAST: alu_nxt = a_s1;
      default: alu_nxt = '0;
    endcase
    for (int i = 0; i < 4; i++) begin
      ac[i] = a_s1[32*i +: 32];
      bc[i] = b_s1[32*i +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    cmd2_r   <= in_r.cmd;
    tag2_r   <= in_r.tag;
    a2_r     <= a_s1;
    b2_r     <= b_s1;
    alu2_r   <= alu_nxt;
    carry2_r <= carry_nxt;
    shovf2_r <= shovf_nxt;
    // Only the product terms that reach the low 128 bits
    pp_r[0]  <= ac[0] * bc[0];
    pp_r[1]  <= ac[0] * bc[1];
    pp_r[2]  <= ac[1] * bc[0];
    pp_r[3]  <= ac[1] * bc[1];
    pp_r[4]  <= ac[0] * bc[2];
    pp_r[5]  <= ac[2] * bc[0];
    pp_r[6]  <= ac[0] * bc[3];
    pp_r[7]  <= ac[1] * bc[2];
    pp_r[8]  <= ac[2] * bc[1];
    pp_r[9]  <= ac[3] * bc[0];
  end

  always_comb begin
    logic [31:0] top32;
    top32   = pp_r[6][31:0] + pp_r[7][31:0] + pp_r[8][31:0] + pp_r[9][31:0];
    prod_s2 = {64'd0, pp_r[0]}
            + {32'd0, pp_r[1], 32'd0}
            + {32'd0, pp_r[2], 32'd0}
            + {pp_r[3], 64'd0}
            + {pp_r[4], 64'd0}
            + {pp_r[5], 64'd0}
            + {top32, 96'd0};
    side_nxt.res    = (cmd2_r == OP_MUL) ? (prod_s2 & width_mask(tag2_r)) : alu2_r;
    side_nxt.carry  = carry2_r;
    side_nxt.shovf  = shovf2_r;
    side_nxt.is_div = (cmd2_r == OP_DIV);
    side_nxt.dz     = (cmd2_r == OP_DIV) && (b2_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    a3_r    <= a2_r;
    b3_r    <= b2_r;
    side3_r <= side_nxt;
  end

  tia_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_a      (a3_r),
    .in_b      (b3_r),
    .in_side   (side3_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_rem   (dv_rem),
    .out_side  (dv_side)
  );

  always_comb begin
    out_nxt = '0;
    out_nxt.carry          = dv_side.carry;
    out_nxt.shift_overflow = dv_side.shovf;
    out_nxt.divide_by_zero = dv_side.dz;
    if (dv_side.is_div) begin
      if (!dv_side.dz) begin
        out_nxt.result_low     = dv_quo[HalfW-1:0];
        out_nxt.result_high    = dv_quo[DataW-1:HalfW];
        out_nxt.remainder_low  = dv_rem[HalfW-1:0];
        out_nxt.remainder_high = dv_rem[DataW-1:HalfW];
      end
    end else begin
      out_nxt.result_low  = dv_side.res[HalfW-1:0];
      out_nxt.result_high = dv_side.res[DataW-1:HalfW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid;
    end
    out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ===== sv/tia_div_pipe.sv =====
// ----------------------------------------------------------------------------
// tia_div_pipe
// Restoring divider, one quotient bit per register stage, with side data.
// ----------------------------------------------------------------------------
`default_nettype none
module tia_div_pipe (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [tia_pkg::DataW-1:0] in_a,
  input  wire logic [tia_pkg::DataW-1:0] in_b,
  input  wire tia_pkg::side_t            in_side,
  output logic                           out_valid,
  output logic [tia_pkg::DataW-1:0]      out_quo,
  output logic [tia_pkg::DataW-1:0]      out_rem,
  output tia_pkg::side_t                 out_side
);
  import tia_pkg::*;

  logic             vld_r  [DivSteps];
  logic [DataW-1:0] rem_r  [DivSteps];
  logic [DataW-1:0] aq_r   [DivSteps];
  logic [DataW-1:0] dvs_r  [DivSteps];
  side_t            side_r [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic             vld_in;
    logic [DataW-1:0] rem_in;
    logic [DataW-1:0] aq_in;
    logic [DataW-1:0] dvs_in;
    side_t            side_in;
    logic [DataW:0]   rem_sh;
    logic [DataW:0]   rem_sub;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign aq_in   = in_a;
      assign dvs_in  = in_b;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign aq_in   = aq_r[k-1];
      assign dvs_in  = dvs_r[k-1];
      assign side_in = side_r[k-1];
    end

    // Bring down the next dividend bit, subtract when the divisor fits.
    assign rem_sh  = {rem_in, aq_in[DataW-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_in};
    assign ge      = (rem_sh >= {1'b0, dvs_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
      rem_r[k]  <= ge ? rem_sub[DataW-1:0] : rem_sh[DataW-1:0];
      aq_r[k]   <= {aq_in[DataW-2:0], ge};
      dvs_r[k]  <= dvs_in;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = vld_r[DivSteps-1];
  assign out_quo   = aq_r[DivSteps-1];
  assign out_rem   = rem_r[DivSteps-1];
  assign out_side  = side_r[DivSteps-1];

endmodule
`default_nettype wire

// ===== sv/tia_checker.sv =====
// ----------------------------------------------------------------------------
// tia_checker
// Port-level checks of the tagged integer ALU result flags and handshake.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tia_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire tia_pkg::in_t  in_item,
  input wire logic          out_valid,
  input wire tia_pkg::out_t out_item
);
  import tia_pkg::*;

  logic rst_seen;
  logic res_zero;
  logic rem_zero;
  logic ovf_clean;
  logic carry_clean;

  assign res_zero    = (out_item.result_low == '0) && (out_item.result_high == '0);
  assign rem_zero    = (out_item.remainder_low == '0) && (out_item.remainder_high == '0);
  assign ovf_clean   = res_zero && !out_item.carry && !out_item.divide_by_zero;
  assign carry_clean = !out_item.shift_overflow && !out_item.divide_by_zero && rem_zero;

  always_ff @(posedge clk) begin
    rst_seen <= rst_n;
  end

  `AST_NEVER(a_in_known, clk, rst_n, start && !busy && $isunknown(in_item))
  `AST_IMPLY(a_busy_drops, clk, rst_n, rst_seen, !busy)
  `AST_IMPLY(a_dz_zero, clk, rst_n, out_valid && out_item.divide_by_zero, res_zero && rem_zero)
  `AST_IMPLY(a_ovf_zero, clk, rst_n, out_valid && out_item.shift_overflow, ovf_clean)
  `AST_IMPLY(a_flags_excl, clk, rst_n, out_valid && out_item.carry, carry_clean)

endmodule

bind tagged_integer_alu_top tia_checker u_tia_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the tagged integer ALU against a behavioral predictor: directed
// edge cases, then random beats with bursty issue and a 128-bit-aware mix.
// ----------------------------------------------------------------------------
`default_nettype none

class alu_scoreboard;
  tia_pkg::out_t pending_results[$];
  int n_errors;
  int n_checked;

  function automatic logic [127:0] mask_of(logic [2:0] tag);
    case (tag)
      tia_pkg::TAG_U8:  return 128'hFF;
      tia_pkg::TAG_U16: return 128'hFFFF;
      tia_pkg::TAG_U32: return 128'hFFFF_FFFF;
      tia_pkg::TAG_U64: return {64'd0, {64{1'b1}}};
      default:          return {128{1'b1}};
    endcase
  endfunction

  function automatic tia_pkg::out_t compute_alu(tia_pkg::in_t it);
    tia_pkg::out_t r;
    logic [127:0] m, a, b, res, rem;
    logic [128:0] sum;
    logic [8:0] w;
    logic [7:0] cnt;
    r = '0;
    m = mask_of(it.tag);
    w = (it.tag <= 3'd4) ? (9'd8 << it.tag) : 9'd128;
    a = {it.a_high, it.a_low} & m;
    b = {it.b_high, it.b_low} & m;
    cnt = it.b_low[7:0];
    res = '0;
    rem = '0;
    case (it.cmd)
      tia_pkg::OP_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        res = sum[127:0] & m;
        r.carry = res < a;
      end
      tia_pkg::OP_SUB: begin
        res = (a - b) & m;
        r.carry = a < b;
      end
      tia_pkg::OP_MUL: res = (a * b) & m;
      tia_pkg::OP_DIV: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else begin
          res = a / b;
          rem = a % b;
        end
      end
      tia_pkg::OP_EQ:  res = (a == b) ? 128'd1 : 128'd0;
      tia_pkg::OP_LT:  res = (a < b) ? 128'd1 : 128'd0;
      tia_pkg::OP_LTE: res = (a <= b) ? 128'd1 : 128'd0;
      tia_pkg::OP_NOT: res = ~a & m;
      tia_pkg::OP_SHL: begin
        if ({1'b0, cnt} >= w) r.shift_overflow = 1'b1;
        else res = (a << cnt) & m;
      end
      tia_pkg::OP_SHR: begin
        if ({1'b0, cnt} >= w) r.shift_overflow = 1'b1;
        else res = a >> cnt;
      end
      tia_pkg::OP_CAST: res = a;
      default: res = '0;
    endcase
    r.result_low = res[63:0];
    r.result_high = res[127:64];
    r.remainder_low = rem[63:0];
    r.remainder_high = rem[127:64];
    return r;
  endfunction

  function void note_input(tia_pkg::in_t it);
    pending_results.insert(pending_results.size(), compute_alu(it));
  endfunction

  function void check_result(tia_pkg::out_t got);
    tia_pkg::out_t exp;
    n_checked++;
    if (pending_results.size() == 0) begin
      $error("result beat with nothing expected");
      n_errors++;
      return;
    end
    exp = pending_results.pop_front();
    if (got.result_low !== exp.result_low) begin
      $error("result_low exp %h got %h", exp.result_low, got.result_low); n_errors++;
    end
    if (got.result_high !== exp.result_high) begin
      $error("result_high exp %h got %h", exp.result_high, got.result_high); n_errors++;
    end
    if (got.remainder_low !== exp.remainder_low) begin
      $error("remainder_low exp %h got %h", exp.remainder_low, got.remainder_low);
      n_errors++;
    end
    if (got.remainder_high !== exp.remainder_high) begin
      $error("remainder_high exp %h got %h", exp.remainder_high, got.remainder_high);
      n_errors++;
    end
    if (got.carry !== exp.carry) begin
      $error("carry exp %b got %b", exp.carry, got.carry); n_errors++;
    end
    if (got.shift_overflow !== exp.shift_overflow) begin
      $error("shift_overflow exp %b got %b", exp.shift_overflow, got.shift_overflow);
      n_errors++;
    end
    if (got.divide_by_zero !== exp.divide_by_zero) begin
      $error("divide_by_zero exp %b got %b", exp.divide_by_zero, got.divide_by_zero);
      n_errors++;
    end
  endfunction
endclass

module tb;
  import tia_pkg::*;

  localparam int Latency = 132;
  localparam int CycleLimit = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_item = '0;
  logic out_valid;
  out_t out_item;
  int cycle_count = 0;
  int n_sent = 0;
  alu_scoreboard alu_sb;

  tagged_integer_alu_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) alu_sb.check_result(out_item);
    if (rst_n && start && !busy) begin
      alu_sb.note_input(in_item);
      n_sent <= n_sent + 1;
    end
    if (cycle_count > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Bias operands toward edge values so carries and compares get exercised.
  function automatic logic [63:0] pick_half();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return {64{1'b1}};
      2: return 64'd1 << $urandom_range(0, 63);
      3: return {56'd0, 8'($urandom())};
      default: return rand64();
    endcase
  endfunction

  // Hold start for one beat until it is taken.
  task automatic send_beat(in_t it);
    in_item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_op(logic [3:0] cmd, logic [2:0] tag, logic [127:0] a,
                         logic [127:0] b);
    in_t it;
    it.cmd = cmd;
    it.tag = tag;
    it.a_low = a[63:0];
    it.a_high = a[127:64];
    it.b_low = b[63:0];
    it.b_high = b[127:64];
    send_beat(it);
  endtask

  initial begin
    in_t it;
    int burst;
    logic [127:0] ones;
    alu_sb = new();
    ones = {128{1'b1}};
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, every opcode, and the named special cases.
    send_op(OP_ADD, TAG_U8, ones, 128'd1);
    send_op(OP_ADD, TAG_U128, ones, ones);
    send_op(OP_SUB, TAG_U16, 128'd0, 128'd1);
    send_op(OP_SUB, TAG_U128, 128'd0, ones);
    send_op(OP_MUL, TAG_U64, ones, ones);
    send_op(OP_MUL, TAG_U128, ones, ones);
    send_op(OP_DIV, TAG_U128, ones, 128'd7);
    send_op(OP_DIV, TAG_U32, 128'd99, {64'd5, 64'd0});
    send_op(OP_DIV, TAG_U128, ones, ones);
    send_op(OP_EQ, TAG_U8, 128'h1FF, 128'hFF);
    send_op(OP_LT, TAG_U128, {64'd1, 64'd0}, {64'd1, 64'd1});
    send_op(OP_LTE, TAG_U64, ones, ones);
    send_op(OP_NOT, TAG_U32, 128'd0, ones);
    send_op(OP_NOT, TAG_U128, 128'd0, 128'd0);
    send_op(OP_SHL, TAG_U128, ones, {64'hFFFF, 64'd127});
    send_op(OP_SHL, TAG_U8, ones, 128'd8);
    send_op(OP_SHR, TAG_U128, ones, 128'd64);
    send_op(OP_SHR, TAG_U128, ones, 128'd255);
    send_op(OP_SHR, TAG_U16, ones, 128'd0);
    send_op(OP_CAST, TAG_U8, ones, ones);
    send_op(OP_CAST, 3'd7, ones, 128'd0);
    send_op(OP_ADD, 3'd5, ones, 128'd1);
    send_op(4'd11, TAG_U64, ones, ones);
    send_op(4'd15, TAG_U128, ones, ones);

    // Random: bursts with random gaps, some long runs back to back.
    while (n_sent < 1550) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        it.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                              : 4'($urandom_range(0, 10));
        it.tag = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
        it.a_low = pick_half();
        it.a_high = pick_half();
        it.b_low = pick_half();
        it.b_high = pick_half();
        if ($urandom_range(0, 7) == 0) it.b_low = it.a_low;
        if ($urandom_range(0, 7) == 0) it.b_high = it.a_high;
        if ((it.cmd == OP_SHL || it.cmd == OP_SHR) && $urandom_range(0, 1))
          it.b_low[7:0] = 8'($urandom_range(0, 130));
        send_beat(it);
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
    end
    start <= 1'b0;

    while (alu_sb.pending_results.size() != 0) @(negedge clk);
    repeat (Latency + 8) @(negedge clk);

    $display("covered %0d beats, %0d results checked, all opcodes and tags",
             n_sent, alu_sb.n_checked);
    if (alu_sb.n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
